// File: hw/rtl/sote_pkg.sv
// Package: shared widths, opcodes, register indexes and reset values.
package sote_pkg;

  localparam int unsigned MAX_SET_SIZE_DEFAULT = 4096;

  localparam int VALUE_W    = 32;
  localparam int ID_W       = 32;
  localparam int COUNT_W    = 13;
  localparam int FRAC_W     = 16;
  localparam int RATIO_W    = FRAC_W + 1;
  localparam int THRESH_W   = 17;
  localparam int CAP_W      = 16;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MATCH_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MATCHES     = 1'd1;

  localparam logic [THRESH_W-1:0] THRESHOLD_RESET   = 17'd32768;
  localparam logic [CAP_W-1:0]    MAX_MATCHES_RESET = 16'd100;

  typedef enum logic [1:0] {
    OP_BEGIN_A  = 2'd0,
    OP_A_MEMBER = 2'd1,
    OP_B_MEMBER = 2'd2,
    OP_END_B    = 2'd3
  } opcode_t;

endpackage

// File: hw/rtl/sote_ifs.sv
// Interfaces: input word channel and result word channel.
interface sote_in_if import sote_pkg::*; ();
  logic               valid;
  logic               ready;
  opcode_t            opcode;
  logic [VALUE_W-1:0] member_value;
  logic [ID_W-1:0]    set_id;

  modport source (output valid, opcode, member_value, set_id, input ready);
  modport sink   (input valid, opcode, member_value, set_id, output ready);
endinterface

interface sote_out_if import sote_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     reference_id;
  logic [ID_W-1:0]     candidate_id;
  logic [COUNT_W-1:0]  shared_count;
  logic [RATIO_W-1:0]  overlap_ratio;
  logic                store_overflowed;

  modport source (output valid, reference_id, candidate_id, shared_count, overlap_ratio,
                  store_overflowed, input ready);
  modport sink   (input valid, reference_id, candidate_id, shared_count, overlap_ratio,
                  store_overflowed, output ready);
endinterface

// File: hw/rtl/sote_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sote_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/sote_ratio_div.sv
// Radix-2 restoring divider: (count << 16) / length, one quotient bit per cycle.
module sote_ratio_div import sote_pkg::*; #(
  parameter int LEN_W = 13
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [LEN_W-1:0]   dividend,
  input  logic [LEN_W-1:0]   divisor,
  output logic               done,
  output logic [RATIO_W-1:0] quotient
);

  localparam int STEPS = RATIO_W;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [LEN_W:0]   rem;
  logic [LEN_W:0]   rem_sub;
  logic [LEN_W-1:0] divisor_q;
  logic             take;

  always_comb begin
    take    = rem >= {1'b0, divisor_q};
    rem_sub = take ? rem - {1'b0, divisor_q} : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= CNT_W'(STEPS - 1);
        rem       <= {1'b0, dividend};
        divisor_q <= divisor;
      end else if (busy) begin
        quotient <= {quotient[RATIO_W-2:0], take};
        rem      <= {rem_sub[LEN_W-1:0], 1'b0};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

// File: hw/rtl/set_overlap_threshold_engine.sv
// Top level: reference set store, merge walk sequencer and result register.
//
//   channel   dir   handshake          payload
//   item      in    valid/ready        opcode, member_value, set_id
//   result    out   valid/ready        reference_id, candidate_id, shared_count,
//                                      overlap_ratio, store_overflowed
//   cfg       in    cfg_we             cfg_index, cfg_data
//
// Begin-of-A and A member words are taken in idle; a B member word starts a walk
// that reads the store RAM and steps past each smaller A entry, or is taken with no
// walk once the walk is exhausted or ended.
// End of B set starts the ratio divider with a non-empty A set and stays idle with
// an empty one; then a result is loaded when one is due, after any wait for the
// result register to drain.
// Reset is synchronous; no clearing pass, store entries are written before use.
// Input ready drops while a walk, division or result load is in progress.
module set_overlap_threshold_engine import sote_pkg::*; #(
  parameter int unsigned MAX_SET_SIZE = MAX_SET_SIZE_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  sote_in_if.sink               item,
  sote_out_if.source            result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LEN_W  = $clog2(MAX_SET_SIZE + 1);
  localparam int ADDR_W = $clog2(MAX_SET_SIZE);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_SET_SIZE);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DIV, S_EMIT} state_t;

  state_t              state;
  logic [LEN_W-1:0]    length;
  logic [LEN_W-1:0]    pointer;
  logic [LEN_W-1:0]    count;
  logic [CAP_W-1:0]    good;
  logic [ID_W-1:0]     ref_id;
  logic                walk_ended;
  logic                overflow;
  logic [THRESH_W-1:0] threshold;
  logic [CAP_W-1:0]    max_matches;
  logic [VALUE_W-1:0]  b_value;
  logic [ID_W-1:0]     cand_id;
  logic [LEN_W-1:0]    cand_count;
  logic [RATIO_W-1:0]  ratio;

  logic                out_valid;
  logic [ID_W-1:0]     out_ref_id;
  logic [ID_W-1:0]     out_cand_id;
  logic [COUNT_W-1:0]  out_count;
  logic [RATIO_W-1:0]  out_ratio;
  logic                out_overflow;

  logic                accept;
  logic                wr_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [VALUE_W-1:0]  a_word;
  logic                advance;
  logic [LEN_W-1:0]    ptr_inc;
  logic                div_start;
  logic                div_done;
  logic [RATIO_W-1:0]  div_q;

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign ptr_inc    = pointer + 1'b1;
  assign advance    = (state == S_WALK) && (a_word < b_value) && (a_word != '0);
  assign rd_addr    = advance ? ptr_inc[ADDR_W-1:0] : pointer[ADDR_W-1:0];
  assign wr_en      = accept && (item.opcode == OP_A_MEMBER) && (length < LEN_MAX);
  assign div_start  = accept && (item.opcode == OP_END_B) && (length != '0);

  sote_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_SET_SIZE)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (length[ADDR_W-1:0]),
    .wr_data (item.member_value),
    .rd_addr (rd_addr),
    .rd_data (a_word)
  );

  sote_ratio_div #(
    .LEN_W (LEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (count),
    .divisor  (length),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      length      <= '0;
      pointer     <= '0;
      count       <= '0;
      good        <= '0;
      ref_id      <= '0;
      walk_ended  <= 1'b0;
      overflow    <= 1'b0;
      threshold   <= THRESHOLD_RESET;
      max_matches <= MAX_MATCHES_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MATCH_THRESHOLD: threshold   <= cfg_data[THRESH_W-1:0];
          REG_MAX_MATCHES:     max_matches <= cfg_data[CAP_W-1:0];
        endcase
      end
      if (out_valid && result.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (item.opcode)
              OP_BEGIN_A: begin
                ref_id     <= item.set_id;
                length     <= '0;
                good       <= '0;
                overflow   <= 1'b0;
                pointer    <= '0;
                count      <= '0;
                walk_ended <= 1'b0;
              end
              OP_A_MEMBER: begin
                if (length < LEN_MAX) begin
                  length <= length + 1'b1;
                end else begin
                  overflow <= 1'b1;
                end
              end
              OP_B_MEMBER: begin
                b_value <= item.member_value;
                if (!walk_ended && (pointer < length)) begin
                  state <= S_WALK;
                end
              end
              OP_END_B: begin
                cand_id    <= item.set_id;
                cand_count <= count;
                pointer    <= '0;
                count      <= '0;
                walk_ended <= 1'b0;
                if (length != '0) begin
                  state <= S_DIV;
                end
              end
            endcase
          end
        end
        S_WALK: begin
          priority if (a_word > b_value) begin
            state <= S_IDLE;
          end else if (a_word == b_value) begin
            count   <= count + 1'b1;
            pointer <= ptr_inc;
            state   <= S_IDLE;
          end else if (a_word == '0) begin
            walk_ended <= 1'b1;
            state      <= S_IDLE;
          end else begin
            pointer <= ptr_inc;
            if (ptr_inc >= length) begin
              state <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            ratio <= div_q;
            if ((div_q >= threshold) && (good < max_matches)) begin
              state <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || result.ready) begin
            out_valid    <= 1'b1;
            out_ref_id   <= ref_id;
            out_cand_id  <= cand_id;
            out_count    <= COUNT_W'(cand_count);
            out_ratio    <= ratio;
            out_overflow <= overflow;
            good         <= good + 1'b1;
            state        <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign result.valid            = out_valid;
  assign result.reference_id     = out_ref_id;
  assign result.candidate_id     = out_cand_id;
  assign result.shared_count     = out_count;
  assign result.overlap_ratio    = out_ratio;
  assign result.store_overflowed = out_overflow;

  assert property (@(posedge clk) disable iff (rst) (count <= pointer) && (pointer <= length))
    else $error("walk count or pointer beyond reference length");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (!walk_ended && (pointer < length)))
    else $error("walk step outside the live reference range");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (good == ($past(good) + CAP_W'(1))))
    else $error("result loaded without good match count update");

endmodule
